>>> rtl/core/ec_signature_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signature generator
// Concurrent checks clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef EC_SIGNATURE_GENERATOR_TOP_MACROS_SVH
`define EC_SIGNATURE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define ECS_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ecs check failed");

// next-cycle implication
`define ECS_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ecs check failed");

`endif

>>> rtl/core/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg
// Types, codes and constants shared by the signature generator modules.
// ----------------------------------------------------------------------------
package ecs_pkg;

    localparam int FIELD_W = 16;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_PRIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 3'd5;

    localparam logic [FIELD_W-1:0] RST_FIELD_PRIME = 16'd751;
    localparam logic [FIELD_W-1:0] RST_GROUP_ORDER = 16'd13;

    // result status
    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NONCE_ZERO = 2'd1;
    localparam logic [1:0] STS_ZERO_DEN   = 2'd2;
    localparam logic [1:0] STS_NOT_INV    = 2'd3;

    // modular ALU operations
    localparam logic [2:0] OP_MOD = 3'd0;
    localparam logic [2:0] OP_MUL = 3'd1;
    localparam logic [2:0] OP_ADD = 3'd2;
    localparam logic [2:0] OP_SUB = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;

    // operand / destination selects
    localparam logic [3:0] SEL_BX  = 4'd0;
    localparam logic [3:0] SEL_BY  = 4'd1;
    localparam logic [3:0] SEL_CA  = 4'd2;
    localparam logic [3:0] SEL_K   = 4'd3;
    localparam logic [3:0] SEL_H   = 4'd4;
    localparam logic [3:0] SEL_D   = 4'd5;
    localparam logic [3:0] SEL_GX  = 4'd6;
    localparam logic [3:0] SEL_GY  = 4'd7;
    localparam logic [3:0] SEL_A   = 4'd8;
    localparam logic [3:0] SEL_AX  = 4'd9;
    localparam logic [3:0] SEL_AY  = 4'd10;
    localparam logic [3:0] SEL_T   = 4'd11;
    localparam logic [3:0] SEL_U   = 4'd12;
    localparam logic [3:0] SEL_LAM = 4'd13;
    localparam logic [3:0] SEL_Z   = 4'd14;
    localparam logic [3:0] SEL_R   = 4'd15;

    typedef struct packed {
        logic [FIELD_W-1:0] nonce;
        logic [FIELD_W-1:0] msg_hash;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] sig_r;
        logic [FIELD_W-1:0] sig_s;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [2:0]         op;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] m;
    } t_alu_cmd;

    typedef struct packed {
        logic               done;
        logic               fail;
        logic [FIELD_W-1:0] res;
    } t_alu_sts;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       upd;
        logic       go;
        logic [2:0] op;
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       use_q;
        logic [3:0] dst;
    } t_dp_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_lt2;
        logic p_lt2;
        logic q_lt2;
        logic cnt_zero;
        logic alu_done;
        logic alu_fail;
    } t_dp_sts;

endpackage

>>> rtl/core/ec_signature_generator_top.sv
// Run time grows with nonce k: a doubling when k >= 2, then k-2 point additions, each
//   with a modular inverse over the field, and the inverse of k over the group order.
// One signature at a time; the next is taken in the cycle the strobe shows.
// The run time is set by the bit-serial modular ALU.
// Reset: synchronous, active low; control and configuration registers return to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
// ec_signature_generator_top
// Prime-field curve signer: r = x(kG) mod q, s = k^-1 (h + d r) mod q.
// ----------------------------------------------------------------------------
`include "ec_signature_generator_top_macros.svh"

module ec_signature_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ecs_pkg::t_in_item                   i_item,
    output logic                                o_valid,
    output ecs_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ecs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ecs_pkg::FIELD_W-1:0]         i_cfg_data
);
    import ecs_pkg::*;

    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;
    logic [FIELD_W-1:0] sig_r, sig_s;
    logic [1:0]         status;

    assign o_cfg_ready = 1'b1;

    ecs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_status (status)
    );

    ecs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_r         (sig_r),
        .o_s         (sig_s)
    );

    // result transaction: signature fields read as zero on any error
    assign o_item.sig_r  = (status == STS_OK) ? sig_r : '0;
    assign o_item.sig_s  = (status == STS_OK) ? sig_s : '0;
    assign o_item.status = status;

    `ECS_CHECK_NOW(a_valid_when_idle, o_valid, !busy)
    `ECS_CHECK_NEXT(a_valid_single, o_valid, !o_valid)
    `ECS_CHECK_NEXT(a_start_goes_busy, start && !busy, busy)
    `ECS_CHECK_NOW(a_valid_after_work, o_valid, $past(busy))

endmodule

>>> rtl/core/ecs_alu.sv
// ----------------------------------------------------------------------------
// ecs_alu
// Bit-serial modular unit: reduce, multiply, add, subtract and inverse
// (extended Euclid with a restoring divider and shift-add multiplier).
// ----------------------------------------------------------------------------
module ecs_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  ecs_pkg::t_alu_cmd i_cmd,
    output ecs_pkg::t_alu_sts o_sts
);
    import ecs_pkg::*;

    localparam int W     = FIELD_W;
    localparam int CNT_W = $clog2(W + 1);

    localparam logic [2:0] A_IDLE    = 3'd0;
    localparam logic [2:0] A_DIV     = 3'd1;
    localparam logic [2:0] A_MUL     = 3'd2;
    localparam logic [2:0] A_INV_RED = 3'd3;
    localparam logic [2:0] A_INV_DIV = 3'd4;
    localparam logic [2:0] A_INV_MUL = 3'd5;
    localparam logic [2:0] A_INV_SUB = 3'd6;
    localparam logic [2:0] A_DONE    = 3'd7;

    logic [2:0]       r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_dvd, n_dvd, r_dvs, n_dvs, r_rem, n_rem, r_quo, n_quo;
    logic [W-1:0]     r_acc, n_acc, r_a, n_a, r_m, n_m;
    logic [W-1:0]     r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [W-1:0]     r_res, n_res;
    logic             r_fail, n_fail;

    logic [W:0]   rem_sh, rem_sub;
    logic         rem_ge, last;
    logic [W-1:0] rem_nx, quo_nx, dbl, acc_nx, tn;

    // conditional subtract of m from a value below 2m
    function automatic logic [W-1:0] fix(input logic [W:0] x, input logic [W-1:0] m);
        logic [W:0] d;
        d = x - {1'b0, m};
        return (x >= {1'b0, m}) ? d[W-1:0] : x[W-1:0];
    endfunction

    // one divider bit and one multiplier bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_dvd[W-1]};
        rem_ge  = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
        rem_nx  = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        quo_nx  = {r_quo[W-2:0], rem_ge};
        dbl     = fix({r_acc, 1'b0}, r_m);
        acc_nx  = fix({1'b0, dbl} + (r_quo[W-1] ? {1'b0, r_a} : {(W+1){1'b0}}), r_m);
        tn      = fix({1'b0, r_t0} + {1'b0, r_m} - {1'b0, r_acc}, r_m);
        last    = (r_cnt == CNT_W'(1));
    end

    // sequencing
    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_dvd = r_dvd; n_dvs = r_dvs; n_rem = r_rem;
        n_quo = r_quo; n_acc = r_acc; n_a = r_a; n_m = r_m; n_r0 = r_r0;
        n_r1 = r_r1; n_t0 = r_t0; n_t1 = r_t1; n_res = r_res; n_fail = r_fail;
        case (r_st)
            A_IDLE: begin
                if (i_go) begin
                    n_m    = i_cmd.m;
                    n_a    = i_cmd.a;
                    n_fail = 1'b0;
                    n_cnt  = CNT_W'(W);
                    n_dvd  = i_cmd.a;
                    n_dvs  = i_cmd.m;
                    n_rem  = '0;
                    n_acc  = '0;
                    n_quo  = i_cmd.b;
                    case (i_cmd.op)
                        OP_MOD: n_st = A_DIV;
                        OP_MUL: n_st = A_MUL;
                        OP_ADD: begin
                            n_res = fix({1'b0, i_cmd.a} + {1'b0, i_cmd.b}, i_cmd.m);
                            n_st  = A_DONE;
                        end
                        OP_SUB: begin
                            n_res = fix({1'b0, i_cmd.a} + {1'b0, i_cmd.m} - {1'b0, i_cmd.b},
                                        i_cmd.m);
                            n_st  = A_DONE;
                        end
                        OP_INV: begin
                            n_r0 = i_cmd.m;
                            n_t0 = '0;
                            n_t1 = W'(1);
                            n_st = A_INV_RED;
                        end
                        default: n_st = A_DONE;
                    endcase
                end
            end
            A_DIV: begin
                n_rem = rem_nx;
                n_dvd = {r_dvd[W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) begin
                    n_res = rem_nx;
                    n_st  = A_DONE;
                end
            end
            A_MUL: begin
                n_acc = acc_nx;
                n_quo = {r_quo[W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) begin
                    n_res = acc_nx;
                    n_st  = A_DONE;
                end
            end
            A_INV_RED: begin
                n_rem = rem_nx;
                n_dvd = {r_dvd[W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) begin
                    n_r1 = rem_nx;
                    if (rem_nx == '0) begin
                        n_fail = (r_r0 != W'(1));
                        n_res  = r_t0;
                        n_st   = A_DONE;
                    end else begin
                        n_dvd = r_r0;
                        n_dvs = rem_nx;
                        n_rem = '0;
                        n_cnt = CNT_W'(W);
                        n_st  = A_INV_DIV;
                    end
                end
            end
            A_INV_DIV: begin
                n_rem = rem_nx;
                n_quo = quo_nx;
                n_dvd = {r_dvd[W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) begin
                    // quotient times t1, reduced mod m
                    n_acc = '0;
                    n_a   = r_t1;
                    n_cnt = CNT_W'(W);
                    n_st  = A_INV_MUL;
                end
            end
            A_INV_MUL: begin
                n_acc = acc_nx;
                n_quo = {r_quo[W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (last) n_st = A_INV_SUB;
            end
            A_INV_SUB: begin
                n_t0 = r_t1;
                n_t1 = tn;
                n_r0 = r_r1;
                n_r1 = r_rem;
                if (r_rem == '0) begin
                    n_fail = (r_r1 != W'(1));
                    n_res  = r_t1;
                    n_st   = A_DONE;
                end else begin
                    n_dvd = r_r1;
                    n_dvs = r_rem;
                    n_rem = '0;
                    n_cnt = CNT_W'(W);
                    n_st  = A_INV_DIV;
                end
            end
            A_DONE:  n_st = A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt; r_dvd <= n_dvd; r_dvs <= n_dvs; r_rem <= n_rem;
        r_quo <= n_quo; r_acc <= n_acc; r_a <= n_a; r_m <= n_m;
        r_r0 <= n_r0; r_r1 <= n_r1; r_t0 <= n_t0; r_t1 <= n_t1;
        r_res <= n_res; r_fail <= n_fail;
    end

    assign o_sts.done = (r_st == A_DONE);
    assign o_sts.fail = r_fail;
    assign o_sts.res  = r_res;

endmodule

>>> rtl/core/ecs_datapath.sv
// ----------------------------------------------------------------------------
// ecs_datapath
// Configuration registers, working point registers, operand selection and
// the modular ALU.
// ----------------------------------------------------------------------------
module ecs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ecs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ecs_pkg::FIELD_W-1:0]         i_cfg_data,
    input  ecs_pkg::t_in_item                   i_item,
    input  ecs_pkg::t_dp_cmd                    i_cmd,
    output ecs_pkg::t_dp_sts                    o_sts,
    output logic [ecs_pkg::FIELD_W-1:0]         o_r,
    output logic [ecs_pkg::FIELD_W-1:0]         o_s
);
    import ecs_pkg::*;

    localparam int W = FIELD_W;

    logic [W-1:0] r_ca, r_p, r_q, r_bx, r_by, r_d;
    logic [W-1:0] r_k, r_h, r_gx, r_gy, r_a, r_ax, r_ay, r_t, r_u, r_lam, r_z, r_r;
    logic [W-1:0] r_cnt;

    t_alu_cmd alu_cmd;
    t_alu_sts alu_sts;

    function automatic logic [W-1:0] pick(input logic [3:0] sel,
        input logic [W-1:0] bx, by, ca, k, h, d, gx, gy, a, ax, ay, t, u, lam, z, r);
        logic [W-1:0] v;
        case (sel)
            SEL_BX:  v = bx;
            SEL_BY:  v = by;
            SEL_CA:  v = ca;
            SEL_K:   v = k;
            SEL_H:   v = h;
            SEL_D:   v = d;
            SEL_GX:  v = gx;
            SEL_GY:  v = gy;
            SEL_A:   v = a;
            SEL_AX:  v = ax;
            SEL_AY:  v = ay;
            SEL_T:   v = t;
            SEL_U:   v = u;
            SEL_LAM: v = lam;
            SEL_Z:   v = z;
            SEL_R:   v = r;
            default: v = '0;
        endcase
        return v;
    endfunction

    // operand selection
    always_comb begin
        alu_cmd.op = i_cmd.op;
        alu_cmd.a  = pick(i_cmd.a_sel, r_bx, r_by, r_ca, r_k, r_h, r_d, r_gx, r_gy,
                          r_a, r_ax, r_ay, r_t, r_u, r_lam, r_z, r_r);
        alu_cmd.b  = pick(i_cmd.b_sel, r_bx, r_by, r_ca, r_k, r_h, r_d, r_gx, r_gy,
                          r_a, r_ax, r_ay, r_t, r_u, r_lam, r_z, r_r);
        alu_cmd.m  = i_cmd.use_q ? r_q : r_p;
    end

    ecs_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.go),
        .i_cmd   (alu_cmd),
        .o_sts   (alu_sts)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0;
            r_p  <= RST_FIELD_PRIME;
            r_q  <= RST_GROUP_ORDER;
            r_bx <= '0;
            r_by <= '0;
            r_d  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CURVE_A:     r_ca <= i_cfg_data;
                CFG_FIELD_PRIME: r_p  <= i_cfg_data;
                CFG_GROUP_ORDER: r_q  <= i_cfg_data;
                CFG_BASE_X:      r_bx <= i_cfg_data;
                CFG_BASE_Y:      r_by <= i_cfg_data;
                CFG_PRIVATE_KEY: r_d  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working registers and ALU write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_k <= i_item.nonce;
            r_h <= i_item.msg_hash;
        end
        if (i_cmd.init) begin
            r_ax  <= r_gx;
            r_ay  <= r_gy;
            r_cnt <= r_k - W'(2);
        end
        if (i_cmd.upd) begin
            r_ax  <= r_t;
            r_cnt <= r_cnt - W'(1);
        end
        if (alu_sts.done) begin
            case (i_cmd.dst)
                SEL_GX:  r_gx  <= alu_sts.res;
                SEL_GY:  r_gy  <= alu_sts.res;
                SEL_A:   r_a   <= alu_sts.res;
                SEL_AY:  r_ay  <= alu_sts.res;
                SEL_T:   r_t   <= alu_sts.res;
                SEL_U:   r_u   <= alu_sts.res;
                SEL_LAM: r_lam <= alu_sts.res;
                SEL_Z:   r_z   <= alu_sts.res;
                SEL_R:   r_r   <= alu_sts.res;
                default: ;
            endcase
        end
    end

    // status back to the controller
    assign o_sts.k_zero   = (r_k == '0);
    assign o_sts.k_lt2    = (r_k < W'(2));
    assign o_sts.p_lt2    = (r_p < W'(2));
    assign o_sts.q_lt2    = (r_q < W'(2));
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.alu_done = alu_sts.done;
    assign o_sts.alu_fail = alu_sts.fail;

    assign o_r = r_r;
    assign o_s = r_t;

endmodule

>>> rtl/core/ecs_ctrl.sv
// ----------------------------------------------------------------------------
// ecs_ctrl
// Sequencer for the signature: base reduction, point doubling, repeated
// point addition, then r and s over the group order.
// ----------------------------------------------------------------------------
module ecs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ecs_pkg::t_dp_sts i_sts,
    output ecs_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_valid,
    output logic [1:0]       o_status
);
    import ecs_pkg::*;

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_CHK   = 6'd1;
    localparam logic [5:0] S_GX    = 6'd2;
    localparam logic [5:0] S_GY    = 6'd3;
    localparam logic [5:0] S_A     = 6'd4;
    localparam logic [5:0] S_INIT  = 6'd5;
    localparam logic [5:0] S_D_T   = 6'd6;
    localparam logic [5:0] S_D_U1  = 6'd7;
    localparam logic [5:0] S_D_U2  = 6'd8;
    localparam logic [5:0] S_D_NUM = 6'd9;
    localparam logic [5:0] S_D_DEN = 6'd10;
    localparam logic [5:0] S_INV_P = 6'd11;
    localparam logic [5:0] S_F_LAM = 6'd12;
    localparam logic [5:0] S_F_T1  = 6'd13;
    localparam logic [5:0] S_F_T2  = 6'd14;
    localparam logic [5:0] S_F_T3  = 6'd15;
    localparam logic [5:0] S_F_U1  = 6'd16;
    localparam logic [5:0] S_F_U2  = 6'd17;
    localparam logic [5:0] S_F_AY  = 6'd18;
    localparam logic [5:0] S_F_UPD = 6'd19;
    localparam logic [5:0] S_A_NUM = 6'd20;
    localparam logic [5:0] S_A_DEN = 6'd21;
    localparam logic [5:0] S_QCHK  = 6'd22;
    localparam logic [5:0] S_Z     = 6'd23;
    localparam logic [5:0] S_R     = 6'd24;
    localparam logic [5:0] S_HQ    = 6'd25;
    localparam logic [5:0] S_DQ    = 6'd26;
    localparam logic [5:0] S_DR    = 6'd27;
    localparam logic [5:0] S_SUM   = 6'd28;
    localparam logic [5:0] S_SIG   = 6'd29;

    logic [5:0] r_state, n_state, nxt;
    logic       r_wait, n_wait, r_valid, n_valid;
    logic [1:0] r_status, n_status;
    logic       is_alu;

    // ALU operation issued in each ALU state
    always_comb begin
        o_cmd  = '0;
        is_alu = 1'b1;
        nxt    = S_IDLE;
        case (r_state)
            S_GX: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_BX; o_cmd.dst = SEL_GX; nxt = S_GY;
            end
            S_GY: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_BY; o_cmd.dst = SEL_GY; nxt = S_A;
            end
            S_A: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_CA; o_cmd.dst = SEL_A; nxt = S_INIT;
            end
            S_D_T: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_GX; o_cmd.b_sel = SEL_GX;
                o_cmd.dst = SEL_T; nxt = S_D_U1;
            end
            S_D_U1: begin
                o_cmd.op = OP_ADD; o_cmd.a_sel = SEL_T; o_cmd.b_sel = SEL_T;
                o_cmd.dst = SEL_U; nxt = S_D_U2;
            end
            S_D_U2: begin
                o_cmd.op = OP_ADD; o_cmd.a_sel = SEL_U; o_cmd.b_sel = SEL_T;
                o_cmd.dst = SEL_U; nxt = S_D_NUM;
            end
            S_D_NUM: begin
                o_cmd.op = OP_ADD; o_cmd.a_sel = SEL_U; o_cmd.b_sel = SEL_A;
                o_cmd.dst = SEL_T; nxt = S_D_DEN;
            end
            S_D_DEN: begin
                o_cmd.op = OP_ADD; o_cmd.a_sel = SEL_GY; o_cmd.b_sel = SEL_GY;
                o_cmd.dst = SEL_U; nxt = S_INV_P;
            end
            S_INV_P: begin
                o_cmd.op = OP_INV; o_cmd.a_sel = SEL_U; o_cmd.dst = SEL_U; nxt = S_F_LAM;
            end
            S_F_LAM: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_T; o_cmd.b_sel = SEL_U;
                o_cmd.dst = SEL_LAM; nxt = S_F_T1;
            end
            S_F_T1: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_LAM; o_cmd.b_sel = SEL_LAM;
                o_cmd.dst = SEL_T; nxt = S_F_T2;
            end
            S_F_T2: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_T; o_cmd.b_sel = SEL_AX;
                o_cmd.dst = SEL_T; nxt = S_F_T3;
            end
            S_F_T3: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_T; o_cmd.b_sel = SEL_GX;
                o_cmd.dst = SEL_T; nxt = S_F_U1;
            end
            S_F_U1: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_AX; o_cmd.b_sel = SEL_T;
                o_cmd.dst = SEL_U; nxt = S_F_U2;
            end
            S_F_U2: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_LAM; o_cmd.b_sel = SEL_U;
                o_cmd.dst = SEL_U; nxt = S_F_AY;
            end
            S_F_AY: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_U; o_cmd.b_sel = SEL_AY;
                o_cmd.dst = SEL_AY; nxt = S_F_UPD;
            end
            S_A_NUM: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_GY; o_cmd.b_sel = SEL_AY;
                o_cmd.dst = SEL_T; nxt = S_A_DEN;
            end
            S_A_DEN: begin
                o_cmd.op = OP_SUB; o_cmd.a_sel = SEL_GX; o_cmd.b_sel = SEL_AX;
                o_cmd.dst = SEL_U; nxt = S_INV_P;
            end
            S_Z: begin
                o_cmd.op = OP_INV; o_cmd.a_sel = SEL_K; o_cmd.use_q = 1'b1;
                o_cmd.dst = SEL_Z; nxt = S_R;
            end
            S_R: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_AX; o_cmd.use_q = 1'b1;
                o_cmd.dst = SEL_R; nxt = S_HQ;
            end
            S_HQ: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_H; o_cmd.use_q = 1'b1;
                o_cmd.dst = SEL_T; nxt = S_DQ;
            end
            S_DQ: begin
                o_cmd.op = OP_MOD; o_cmd.a_sel = SEL_D; o_cmd.use_q = 1'b1;
                o_cmd.dst = SEL_U; nxt = S_DR;
            end
            S_DR: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_U; o_cmd.b_sel = SEL_R;
                o_cmd.use_q = 1'b1; o_cmd.dst = SEL_U; nxt = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_ADD; o_cmd.a_sel = SEL_T; o_cmd.b_sel = SEL_U;
                o_cmd.use_q = 1'b1; o_cmd.dst = SEL_T; nxt = S_SIG;
            end
            S_SIG: begin
                o_cmd.op = OP_MUL; o_cmd.a_sel = SEL_Z; o_cmd.b_sel = SEL_T;
                o_cmd.use_q = 1'b1; o_cmd.dst = SEL_T; nxt = S_IDLE;
            end
            default: is_alu = 1'b0;
        endcase

        // state transitions
        n_state  = r_state;
        n_wait   = r_wait;
        n_valid  = 1'b0;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.k_zero) begin
                    n_valid = 1'b1; n_status = STS_NONCE_ZERO; n_state = S_IDLE;
                end else if (i_sts.p_lt2) begin
                    n_valid = 1'b1; n_status = STS_ZERO_DEN; n_state = S_IDLE;
                end else begin
                    n_state = S_GX;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_sts.k_lt2 ? S_QCHK : S_D_T;
            end
            S_F_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.cnt_zero ? S_QCHK : S_A_NUM;
            end
            S_QCHK: begin
                if (i_sts.q_lt2) begin
                    n_valid = 1'b1; n_status = STS_NOT_INV; n_state = S_IDLE;
                end else begin
                    n_state = S_Z;
                end
            end
            default: begin
                if (is_alu) begin
                    if (!r_wait) begin
                        o_cmd.go = 1'b1;
                        n_wait   = 1'b1;
                    end else if (i_sts.alu_done) begin
                        n_wait = 1'b0;
                        if (r_state == S_INV_P && i_sts.alu_fail) begin
                            n_valid = 1'b1; n_status = STS_ZERO_DEN; n_state = S_IDLE;
                        end else if (r_state == S_Z && i_sts.alu_fail) begin
                            n_valid = 1'b1; n_status = STS_NOT_INV; n_state = S_IDLE;
                        end else if (r_state == S_SIG) begin
                            n_valid = 1'b1; n_status = STS_OK; n_state = S_IDLE;
                        end else begin
                            n_state = nxt;
                        end
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= STS_OK;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

>>> sim/ecs_sig_checker.sv
// ----------------------------------------------------------------------------
// Signature checker
// Watches the configuration, command and result channels of the signer.
// For every accepted command it predicts (r, s, status) from its own copy of
// the registers, then matches each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module ecs_sig_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  ecs_pkg::t_in_item             i_item,
    input  logic                          o_valid,
    input  ecs_pkg::t_out_item            o_item,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [ecs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ecs_pkg::FIELD_W-1:0]   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import ecs_pkg::*;

    // register shadow
    longint curve_a, field_p, order_q, gen_x, gen_y, priv_d;
    // running point
    longint pt_x, pt_y, op_count;

    ecs_pkg::t_out_item sig_expect_q[$];

    // extended Euclid; returns 0 when v has no inverse mod m
    function automatic bit mod_inverse(input longint v, input longint m,
                                       output longint res);
        longint r0, r1, rn, qt, t0, t1, tn;
        r0 = m; r1 = v % m; t0 = 0; t1 = 1; res = 0;
        while (r1 != 0) begin
            qt = r0 / r1;
            rn = r0 - qt * r1; r0 = r1; r1 = rn;
            tn = t0 - qt * t1; t0 = t1; t1 = tn;
        end
        if (r0 != 1)
            return 0;
        res = (t0 < 0) ? (m - ((-t0) % m)) % m : t0 % m;
        return 1;
    endfunction

    function automatic longint sub_mod(input longint x, input longint y, input longint m);
        return (x + m - y) % m;
    endfunction

    // one doubling or addition; x2 is the other abscissa
    function automatic bit point_op(input longint num, input longint den,
                                    input longint x1, input longint y1,
                                    input longint x2, input longint p);
        longint inv, lam, x3, y3;
        if (den % p == 0 || !mod_inverse(den, p, inv))
            return 0;
        lam = (num % p) * inv % p;
        x3 = sub_mod(sub_mod(lam * lam % p, x1, p), x2, p);
        y3 = sub_mod(lam * sub_mod(x1, x3, p) % p, y1, p);
        pt_x = x3 & 64'hFFFF;
        pt_y = y3 & 64'hFFFF;
        op_count = (op_count + 1) & 64'hFFFF;
        return 1;
    endfunction

    function automatic ecs_pkg::t_out_item predict_signature(input logic [15:0] nonce,
                                                             input logic [15:0] hash);
        ecs_pkg::t_out_item res;
        longint k, h, p, q, gx, gy, a, x1, y1, z, r, s, i;
        logic [1:0] sts;
        k = nonce; h = hash; p = field_p; q = order_q;
        res = '0;
        sts = STS_OK;
        if (k == 0) begin
            res.status = STS_NONCE_ZERO;
            return res;
        end
        if (p < 2) begin
            res.status = STS_ZERO_DEN;
            return res;
        end
        gx = gen_x % p; gy = gen_y % p; a = curve_a % p;
        op_count = 0; pt_x = gx; pt_y = gy;
        if (k >= 2) begin
            if (!point_op((3 * (gx * gx % p) + a) % p, 2 * gy, gx, gy, gx, p))
                sts = STS_ZERO_DEN;
            for (i = 3; sts == STS_OK && i <= k; i++) begin
                x1 = pt_x; y1 = pt_y;
                if (!point_op(sub_mod(gy, y1, p), sub_mod(gx, x1, p), x1, y1, gx, p))
                    sts = STS_ZERO_DEN;
            end
        end
        if (sts == STS_OK) begin
            if (q < 2 || !mod_inverse(k % q, q, z)) begin
                sts = STS_NOT_INV;
            end else begin
                r = pt_x % q;
                s = (h % q + (priv_d % q) * r % q) % q;
                s = z * s % q;
                res.sig_r = r[15:0];
                res.sig_s = s[15:0];
            end
        end
        res.status = sts;
        return res;
    endfunction

    // shadow registers, prediction and comparison
    always @(posedge i_clk) begin
        ecs_pkg::t_out_item exp_sig;
        if (!i_rst_n) begin
            curve_a <= 0; field_p <= RST_FIELD_PRIME; order_q <= RST_GROUP_ORDER;
            gen_x <= 0; gen_y <= 0; priv_d <= 0;
            pt_x = 0; pt_y = 0; op_count = 0;
            sig_expect_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CURVE_A:     curve_a <= i_cfg_data;
                    CFG_FIELD_PRIME: field_p <= i_cfg_data;
                    CFG_GROUP_ORDER: order_q <= i_cfg_data;
                    CFG_BASE_X:      gen_x   <= i_cfg_data;
                    CFG_BASE_Y:      gen_y   <= i_cfg_data;
                    CFG_PRIVATE_KEY: priv_d  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                sig_expect_q.push_back(predict_signature(i_item.nonce, i_item.msg_hash));
            if (o_valid) begin
                if (sig_expect_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result r=%0d s=%0d status=%0d",
                                 o_item.sig_r, o_item.sig_s, o_item.status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_sig = sig_expect_q.pop_front();
                    if (o_item.sig_r !== exp_sig.sig_r || o_item.sig_s !== exp_sig.sig_s ||
                        o_item.status !== exp_sig.status) begin
                        if (o_fail_count < 10)
                            $display("result differs: expected r=%0d s=%0d status=%0d, got r=%0d s=%0d status=%0d",
                                     exp_sig.sig_r, exp_sig.sig_s, exp_sig.status,
                                     o_item.sig_r, o_item.sig_s, o_item.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= sig_expect_q.size();
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Signature generator testbench
// Drives configuration phases and nonce/hash commands, mostly with random gaps; the
// checker predicts and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import ecs_pkg::*;

    localparam int IDLE_LIMIT = 600000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    ecs_pkg::t_in_item      i_item;
    logic                   o_valid;
    ecs_pkg::t_out_item     o_item;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [FIELD_W-1:0]     i_cfg_data;
    int                     fail_count;
    int                     pending;
    logic                   cfg_taken, cmd_taken;
    int                     idle_cycles;
    bit                     no_gaps;

    ec_signature_generator_top dut (.*);

    ecs_sig_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_valid, .o_item,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // transaction flags and watchdog
    always @(posedge i_clk) begin
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        cmd_taken <= start && !busy;
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ec_signature_generator_top: mismatch");
                $finish;
            end
        end
    end

    task automatic pause();
        if (!no_gaps)
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        pause();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic sign(input logic [15:0] k, input logic [15:0] h);
        pause();
        start = 1'b1;
        i_item.nonce = k;
        i_item.msg_hash = h;
        do @(negedge i_clk); while (!cmd_taken);
        start = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic load_curve(input logic [15:0] a, input logic [15:0] p,
                              input logic [15:0] q, input logic [15:0] gx,
                              input logic [15:0] gy, input logic [15:0] d);
        drain();
        write_reg(CFG_CURVE_A, a);
        write_reg(CFG_FIELD_PRIME, p);
        write_reg(CFG_GROUP_ORDER, q);
        write_reg(CFG_BASE_X, gx);
        write_reg(CFG_BASE_Y, gy);
        write_reg(CFG_PRIVATE_KEY, d);
    endtask

    // small nonces keep the point walk short; a few go further
    function automatic logic [15:0] pick_nonce();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return 16'($urandom_range(13, 40));
        return 16'($urandom_range(1, 12));
    endfunction

    initial begin
        logic [15:0] primes[8];
        primes = '{16'd3, 16'd5, 16'd13, 16'd101, 16'd751, 16'd4093, 16'd65521, 16'd65519};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        no_gaps = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: G = (0,0) makes every doubling hit infinity
        sign(16'd0, 16'd7);
        sign(16'd1, 16'hFFFF);
        sign(16'd2, 16'd5);
        sign(16'hFFFF, 16'd0);

        // ordinary curve, q = 13 so k = 13 cannot be inverted
        load_curve(16'd1, 16'd751, 16'd13, 16'd5, 16'd34, 16'd9);
        sign(16'd1, 16'd100);
        sign(16'd3, 16'd0);
        sign(16'd7, 16'hFFFF);
        sign(16'd13, 16'd1);
        // composite group order: k = 6 shares a factor with 12
        drain();
        write_reg(CFG_GROUP_ORDER, 16'd12);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        sign(16'd6, 16'd3);
        sign(16'd5, 16'd3);

        // extremes of every register
        load_curve(16'hFFFF, 16'd65521, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sign(16'd2, 16'hFFFF);
        sign(16'd4, 16'h0000);
        load_curve(16'd0, 16'd3, 16'd2, 16'd0, 16'd1, 16'd0);
        sign(16'd1, 16'd1);
        sign(16'd2, 16'd1);
        sign(16'd3, 16'd2);
        // composite field prime: denominators may have no inverse
        load_curve(16'd3, 16'hFFFF, 16'd65521, 16'd6, 16'd5, 16'd77);
        sign(16'd2, 16'd9);
        sign(16'd5, 16'd9);

        // random curves with random content
        for (int ph = 0; ph < 6; ph++) begin
            logic [15:0] p, q;
            p = (ph == 5) ? 16'($urandom_range(3, 65535)) : primes[$urandom_range(0, 7)];
            q = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(2, 65535))
                                            : primes[$urandom_range(0, 7)];
            load_curve(16'($urandom), p, q, 16'($urandom), 16'($urandom), 16'($urandom));
            no_gaps = (ph == 2);
            repeat (14) sign(pick_nonce(), 16'($urandom));
        end
        no_gaps = 1'b0;

        // y(G) = 0 fails at the doubling, so full-width nonces stay cheap
        load_curve(16'($urandom), 16'($urandom_range(3, 65535)), 16'($urandom_range(2, 65535)),
                   16'($urandom), 16'd0, 16'($urandom));
        repeat (12) sign(16'($urandom), 16'($urandom));

        drain();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("ec_signature_generator_top: match");
        else
            $display("ec_signature_generator_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ecs_pkg.sv
rtl/core/ecs_alu.sv
rtl/core/ecs_datapath.sv
rtl/core/ecs_ctrl.sv
rtl/core/ec_signature_generator_top.sv
sim/ecs_sig_checker.sv
sim/tb_top.sv
